// ===== src/ccp_pkg.sv =====
// Shared types and constants of the circle canvas painter.
// Used by the controller, the datapath and the top level; depends on nothing.
package ccp_pkg;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [7:0] TYPE_FILLED  = 8'h43;
	localparam logic [7:0] TYPE_OUTLINE = 8'h63;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_BG     = 2'd2;

	localparam logic [8:0] WIDTH_RESET  = 9'd0;
	localparam logic [8:0] HEIGHT_RESET = 9'd0;
	localparam logic [7:0] BG_RESET     = 8'd32;

	typedef struct packed {
		logic accept;
		logic load_radius;
		logic latch_radii;
		logic sweep;
		logic clear_wr;
		logic draw_issue;
		logic read_en;
		logic load_result;
	} ccp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       draw_ok;
		logic       empty;
		logic       last_pixel;
		logic       pipe_busy;
	} ccp_stat_t;

endpackage

// ===== src/ccp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/ccp_ctrl.sv =====
// Operation sequencer of the circle canvas painter.
// Uses ccp_pkg; drives the datapath commands and the result valid.
module ccp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  ccp_pkg::ccp_stat_t  stat,
	output ccp_pkg::ccp_cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CLEAR,
		S_RAD0,
		S_RAD1,
		S_RAD2,
		S_DRAW,
		S_DRAIN,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.accept      = (state_q == S_IDLE) && in_valid;
		cmd.load_radius = (state_q == S_RAD0);
		cmd.latch_radii = (state_q == S_RAD2);
		cmd.sweep       = (state_q == S_CLEAR) || (state_q == S_DRAW);
		cmd.clear_wr    = (state_q == S_CLEAR);
		cmd.draw_issue  = (state_q == S_DRAW);
		cmd.read_en     = (state_q == S_DECODE) && (stat.op == ccp_pkg::OP_READ);
		cmd.load_result = (state_q == S_RESULT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			priority if ((state_q == S_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					priority if (stat.op == ccp_pkg::OP_CLEAR) begin
						state_q <= stat.empty ? S_RESULT : S_CLEAR;
					end else if (stat.op == ccp_pkg::OP_DRAW) begin
						state_q <= (!stat.draw_ok || stat.empty) ? S_RESULT : S_RAD0;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_CLEAR: begin
					if (stat.last_pixel) begin
						state_q <= S_RESULT;
					end
				end
				S_RAD0: state_q <= S_RAD1;
				S_RAD1: state_q <= S_RAD2;
				S_RAD2: state_q <= S_DRAW;
				S_DRAW: begin
					if (stat.last_pixel) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_drained_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) |-> !stat.pipe_busy)
		else $error("result reached with paint writes in flight");

	a_sweep_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep && stat.last_pixel) |=> (state_q != S_CLEAR && state_q != S_DRAW))
		else $error("sweep continued past last pixel");

	a_valid_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RESULT))
		else $error("result word raised outside result state");
`endif

endmodule

// ===== src/ccp_datapath.sv =====
// Datapath of the circle canvas painter: config registers, sweep counters,
// distance pipeline and canvas RAM. Uses ccp_pkg and ccp_ram.
module ccp_datapath #(
	parameter int MAX_SIDE  = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data,
	input  logic [1:0]          operation,
	input  logic [7:0]          shape_type,
	input  logic signed [19:0]  center_x,
	input  logic signed [19:0]  center_y,
	input  logic [19:0]         radius,
	input  logic [7:0]          paint_char,
	input  logic [7:0]          pixel_col,
	input  logic [7:0]          pixel_row,
	input  ccp_pkg::ccp_cmd_t   cmd,
	output ccp_pkg::ccp_stat_t  stat,
	output logic                status,
	output logic [7:0]          pixel_value
);

	localparam int CW  = $clog2(MAX_SIDE + 1);
	localparam int LW  = (CW > 9) ? CW : 9;
	localparam int AW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
	localparam int PW  = (CW + FRAC_BITS > 20) ? CW + FRAC_BITS : 20;
	localparam int DXW = PW + 2;
	localparam int MW  = DXW - 1;
	localparam int SQW = 2 * MW;
	localparam logic signed [DXW-1:0] ONE   = DXW'(64'd1 << FRAC_BITS);
	localparam logic [19:0]           R_ONE = 20'(64'd1 << FRAC_BITS);
	localparam logic [AW-1:0]         ROW_STEP = AW'(MAX_SIDE);

	// configuration
	logic [8:0] width_q, height_q;
	logic [7:0] bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ccp_pkg::WIDTH_RESET;
			height_q <= ccp_pkg::HEIGHT_RESET;
			bg_q     <= ccp_pkg::BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ccp_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				ccp_pkg::CFG_HEIGHT: height_q <= cfg_data;
				ccp_pkg::CFG_BG:     bg_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic [LW-1:0] w_ext, h_ext;
	logic [CW-1:0] used_w, used_h;

	assign w_ext  = LW'(width_q);
	assign h_ext  = LW'(height_q);
	assign used_w = (w_ext > LW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(w_ext);
	assign used_h = (h_ext > LW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(h_ext);

	// captured word
	logic [1:0]         op_q;
	logic [7:0]         type_q, ch_q, pcol_q, prow_q;
	logic signed [19:0] cx_q;
	logic [19:0]        r_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= operation;
			type_q <= shape_type;
			cx_q   <= center_x;
			r_q    <= radius;
			ch_q   <= paint_char;
			pcol_q <= pixel_col;
			prow_q <= pixel_row;
		end
	end

	logic draw_ok, has_inner, filled;

	assign draw_ok   = (r_q != '0) &&
		((type_q == ccp_pkg::TYPE_FILLED) || (type_q == ccp_pkg::TYPE_OUTLINE));
	assign has_inner = (r_q >= R_ONE);
	assign filled    = (type_q == ccp_pkg::TYPE_FILLED);

	// sweep counters
	logic [CW-1:0]        col_q, row_q;
	logic [AW-1:0]        addr_q, row_base_q;
	logic signed [DXW-1:0] dx_q, dy_q;
	logic                 col_last, row_last;

	assign col_last = (col_q == used_w - CW'(1));
	assign row_last = (row_q == used_h - CW'(1));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q      <= '0;
			row_q      <= '0;
			addr_q     <= '0;
			row_base_q <= '0;
			dx_q       <= -DXW'(center_x);
			dy_q       <= -DXW'(center_y);
		end else if (cmd.sweep) begin
			if (col_last) begin
				col_q      <= '0;
				row_q      <= row_q + CW'(1);
				row_base_q <= row_base_q + ROW_STEP;
				addr_q     <= row_base_q + ROW_STEP;
				dx_q       <= -DXW'(cx_q);
				dy_q       <= dy_q + ONE;
			end else begin
				col_q  <= col_q + CW'(1);
				addr_q <= addr_q + AW'(1);
				dx_q   <= dx_q + ONE;
			end
		end
	end

	// distance pipeline; also squares the radii before a draw
	logic [MW-1:0]  a_mag, b_mag, a_s1, b_s1;
	logic [SQW-1:0] sqa_s2, sqb_s2, outer_q, inner_q;
	logic [SQW:0]   sum_s3;
	logic [AW-1:0]  addr_s1, addr_s2, addr_s3;
	logic           v_s1, v_s2, v_s3;
	logic           in_disc, border, paint;

	assign a_mag = dx_q[DXW-1] ? MW'(-dx_q) : MW'(dx_q);
	assign b_mag = dy_q[DXW-1] ? MW'(-dy_q) : MW'(dy_q);

	always_ff @(posedge clk) begin
		if (cmd.load_radius) begin
			a_s1 <= MW'(r_q);
			b_s1 <= has_inner ? MW'(r_q - R_ONE) : '0;
		end else begin
			a_s1 <= a_mag;
			b_s1 <= b_mag;
		end
		addr_s1 <= addr_q;
		sqa_s2  <= SQW'(a_s1) * SQW'(a_s1);
		sqb_s2  <= SQW'(b_s1) * SQW'(b_s1);
		addr_s2 <= addr_s1;
		sum_s3  <= {1'b0, sqa_s2} + {1'b0, sqb_s2};
		addr_s3 <= addr_s2;
		if (cmd.latch_radii) begin
			outer_q <= sqa_s2;
			inner_q <= sqb_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.draw_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign in_disc = has_inner && (sum_s3 <= {1'b0, inner_q});
	assign border  = !in_disc && (sum_s3 <= {1'b0, outer_q});
	assign paint   = v_s3 && (border || (in_disc && filled));

	// canvas
	logic          ram_we, read_hit;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	assign ram_we    = cmd.clear_wr || paint;
	assign ram_waddr = cmd.clear_wr ? addr_q : addr_s3;
	assign ram_wdata = cmd.clear_wr ? bg_q : ch_q;
	assign ram_raddr = AW'(32'(prow_q) * 32'(MAX_SIDE) + 32'(pcol_q));
	assign read_hit  = (op_q == ccp_pkg::OP_READ) &&
		(LW'(pcol_q) < LW'(used_w)) && (LW'(prow_q) < LW'(used_h));

	ccp_ram #(
		.WIDTH (8),
		.DEPTH (MAX_SIDE * MAX_SIDE)
	) u_canvas (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.read_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			status      <= (op_q == ccp_pkg::OP_DRAW) && !draw_ok;
			pixel_value <= read_hit ? ram_rdata : 8'd0;
		end
	end

	assign stat.op         = op_q;
	assign stat.draw_ok    = draw_ok;
	assign stat.empty      = (used_w == '0) || (used_h == '0);
	assign stat.last_pixel = col_last && row_last;
	assign stat.pipe_busy  = v_s1 || v_s2 || v_s3;

endmodule

// ===== src/circle_canvas_painter_core.sv =====
// Top level of the circle canvas painter: controller plus datapath.
// Uses ccp_pkg, ccp_ctrl and ccp_datapath.
//
// Usage:
//  Input channel (in_valid / in_stall) takes one word: operation and its
//  fields. Output channel (out_valid / out_stall) returns one word per input:
//  status and pixel_value. A word moves when valid is high and stall is low.
//  cfg_we writes canvas_width (index 0), canvas_height (1) or
//  background_char (2); write only while the block is idle.
//  Work per word, from accept to result valid (W, H = used width, height):
//   clear: W*H canvas RAM writes, one per cycle
//   draw:  one pixel per cycle through a three-stage squared distance
//          pipeline, after the states S_RAD0 to S_RAD2 that square the radii
//   read: one registered RAM read; rejected draw, unused code: no RAM work
//  At most one word is in work; the next is taken as soon as the result
//  sits in the output register, even while the receiver stalls it.
//  A stalled result holds; the block then waits before writing a new one.
//  Reset clears the controller and sets the registers to 0, 0 and 32.
//  The canvas is not cleared by reset: issue a clear before any read.
module circle_canvas_painter_core #(
	parameter int MAX_SIDE  = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [7:0]         shape_type,
	input  logic signed [19:0] center_x,
	input  logic signed [19:0] center_y,
	input  logic [19:0]        radius,
	input  logic [7:0]         paint_char,
	input  logic [7:0]         pixel_col,
	input  logic [7:0]         pixel_row,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [7:0]         pixel_value
);

	ccp_pkg::ccp_cmd_t  cmd;
	ccp_pkg::ccp_stat_t stat;

	ccp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ccp_datapath #(
		.MAX_SIDE  (MAX_SIDE),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.shape_type  (shape_type),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.paint_char  (paint_char),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.pixel_value (pixel_value)
	);

endmodule
